// ===== sv/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// brl_pkg: shared types and constants for the line rasterizer
// Coordinate and address widths, command codes and the pixel record.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int COORD_BITS     = 10;
  localparam int ADDR_BITS      = 20;
  localparam int ROW_WIDTH_BITS = 10;
  localparam int SPAN2_BITS     = COORD_BITS + 1;
  localparam int ERR_BITS       = COORD_BITS + 3;
  localparam int PROD_BITS      = ROW_WIDTH_BITS + ADDR_BITS;

  localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = ROW_WIDTH_BITS'(200);

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   command;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } cmd_t;

  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic                  last_pixel;
  } pixel_t;

endpackage

// ===== sv/brl_cmd_if.sv =====
// ----------------------------------------------------------------------------
// brl_cmd_if: command channel
// Valid/ready channel carrying start and advance commands with endpoints.
// ----------------------------------------------------------------------------
interface brl_cmd_if;
  logic            valid;
  logic            ready;
  logic            command;
  brl_pkg::coord_t x_start;
  brl_pkg::coord_t y_start;
  brl_pkg::coord_t x_end;
  brl_pkg::coord_t y_end;

  modport source (output valid, command, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, command, x_start, y_start, x_end, y_end, output ready);
endinterface

// ===== sv/brl_pix_if.sv =====
// ----------------------------------------------------------------------------
// brl_pix_if: pixel channel
// Valid/ready channel carrying one rasterized pixel per transaction.
// ----------------------------------------------------------------------------
interface brl_pix_if;
  logic                             valid;
  logic                             ready;
  brl_pkg::coord_t                  pixel_x;
  brl_pkg::coord_t                  pixel_y;
  logic [brl_pkg::ADDR_BITS-1:0]    pixel_address;
  logic                             last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_address, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, last_pixel, output ready);
endinterface

// ===== sv/bresenham_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core: Bresenham line rasterizer
// Commands on cmd_i: a start transaction (command 0) loads two 1-based
// endpoints and replaces any active line; an advance transaction (command 1)
// emits the next pixel of the line on pix_o, with its frame-buffer address
// row_width*(y-1)+(x-1) and a last flag. The endpoint with the larger major
// coordinate is not drawn, a zero-span line emits nothing and an advance with
// no active line is dropped. row_width is written through cfg_we_i/cfg_data_i
// by the user only while the block is idle; the block itself does not enforce
// this. Throughput: one command per cycle while cmd_i.ready is high; the
// address multiply sits between the line state and the result register. A
// two-entry result buffer lets one more command in while a pixel waits;
// cmd_i.ready drops when both entries are full and rises as pix_o drains.
// Reset clears the line state, the result buffer and sets row_width to 200.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [brl_pkg::ROW_WIDTH_BITS-1:0]  cfg_data_i,
  brl_cmd_if.sink                             cmd_i,
  brl_pix_if.source                           pix_o
);

  logic [brl_pkg::ROW_WIDTH_BITS-1:0] row_width_q;
  brl_pkg::cmd_t                      cmd;
  brl_pkg::pixel_t                    res, out_data;
  logic                               res_valid, buf_ready, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= brl_pkg::ROW_WIDTH_RESET;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_data_i;
    end
  end

  assign cmd.command = cmd_i.command;
  assign cmd.x_start = cmd_i.x_start;
  assign cmd.y_start = cmd_i.y_start;
  assign cmd.x_end   = cmd_i.x_end;
  assign cmd.y_end   = cmd_i.y_end;

  assign cmd_i.ready = buf_ready;
  assign accept      = cmd_i.valid && buf_ready;

  brl_line_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd),
    .row_width_i (row_width_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  brl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (pix_o.valid),
    .pop_ready_i (pix_o.ready),
    .data_o      (out_data)
  );

  assign pix_o.pixel_x       = out_data.pixel_x;
  assign pix_o.pixel_y       = out_data.pixel_y;
  assign pix_o.pixel_address = out_data.pixel_address;
  assign pix_o.last_pixel    = out_data.last_pixel;

endmodule

// ===== sv/brl_line_engine.sv =====
// ----------------------------------------------------------------------------
// brl_line_engine: line state and per-command update
// Holds the active line, sets it up on start and steps it on advance,
// presenting the current pixel with its frame-buffer address.
// ----------------------------------------------------------------------------
module brl_line_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  brl_pkg::cmd_t                       cmd_i,
  input  logic [brl_pkg::ROW_WIDTH_BITS-1:0]  row_width_i,
  output logic                                res_valid_o,
  output brl_pkg::pixel_t                     res_o
);

  logic                                active_q, active_d;
  logic                                steep_q, steep_d;
  brl_pkg::coord_t                     major_pos_q, major_pos_d;
  brl_pkg::coord_t                     major_stop_q, major_stop_d;
  brl_pkg::coord_t                     minor_pos_q, minor_pos_d;
  logic                                minor_down_q, minor_down_d;
  logic signed [brl_pkg::ERR_BITS-1:0] err_q, err_d;
  logic [brl_pkg::SPAN2_BITS-1:0]      tmaj_q, tmaj_d;
  logic [brl_pkg::SPAN2_BITS-1:0]      tmin_q, tmin_d;

  brl_pkg::coord_t dx, dy, ma0, mi0, ma1, mi1, sma0, smi0, sma1, smi1, major_span, minor_span;
  logic            is_steep;
  logic [brl_pkg::SPAN2_BITS-1:0]      major_next;
  logic                                last;
  logic signed [brl_pkg::ERR_BITS-1:0] err_sub;
  brl_pkg::coord_t                     px, py;
  logic [brl_pkg::ADDR_BITS-1:0]       px_m1, py_m1;
  logic [brl_pkg::PROD_BITS-1:0]       prod;

  // line setup
  always_comb begin
    dx = (cmd_i.x_start > cmd_i.x_end) ? cmd_i.x_start - cmd_i.x_end
                                       : cmd_i.x_end - cmd_i.x_start;
    dy = (cmd_i.y_start > cmd_i.y_end) ? cmd_i.y_start - cmd_i.y_end
                                       : cmd_i.y_end - cmd_i.y_start;
    is_steep = dy > dx;
    if (is_steep) begin
      ma0 = cmd_i.y_start; mi0 = cmd_i.x_start; ma1 = cmd_i.y_end; mi1 = cmd_i.x_end;
      major_span = dy; minor_span = dx;
    end else begin
      ma0 = cmd_i.x_start; mi0 = cmd_i.y_start; ma1 = cmd_i.x_end; mi1 = cmd_i.y_end;
      major_span = dx; minor_span = dy;
    end
    if (ma0 > ma1) begin
      sma0 = ma1; smi0 = mi1; sma1 = ma0; smi1 = mi0;
    end else begin
      sma0 = ma0; smi0 = mi0; sma1 = ma1; smi1 = mi1;
    end
  end

  // pixel and step
  always_comb begin
    px         = steep_q ? minor_pos_q : major_pos_q;
    py         = steep_q ? major_pos_q : minor_pos_q;
    major_next = brl_pkg::SPAN2_BITS'(major_pos_q) + brl_pkg::SPAN2_BITS'(1);
    last       = major_next >= brl_pkg::SPAN2_BITS'(major_stop_q);
    err_sub    = err_q - $signed(brl_pkg::ERR_BITS'(tmin_q));
    px_m1      = brl_pkg::ADDR_BITS'(px) - brl_pkg::ADDR_BITS'(1);
    py_m1      = brl_pkg::ADDR_BITS'(py) - brl_pkg::ADDR_BITS'(1);
    prod       = brl_pkg::PROD_BITS'(row_width_i) * brl_pkg::PROD_BITS'(py_m1);

    res_o.pixel_x       = px;
    res_o.pixel_y       = py;
    res_o.pixel_address = prod[brl_pkg::ADDR_BITS-1:0] + px_m1;
    res_o.last_pixel    = last;
    res_valid_o         = accept_i && (cmd_i.command == brl_pkg::CMD_ADVANCE) && active_q;
  end

  always_comb begin
    active_d     = active_q;
    steep_d      = steep_q;
    major_pos_d  = major_pos_q;
    major_stop_d = major_stop_q;
    minor_pos_d  = minor_pos_q;
    minor_down_d = minor_down_q;
    err_d        = err_q;
    tmaj_d       = tmaj_q;
    tmin_d       = tmin_q;
    if (accept_i && (cmd_i.command == brl_pkg::CMD_START)) begin
      steep_d      = is_steep;
      major_pos_d  = sma0;
      major_stop_d = sma1;
      minor_pos_d  = smi0;
      minor_down_d = smi0 > smi1;
      err_d        = $signed(brl_pkg::ERR_BITS'(major_span));
      tmaj_d       = {major_span, 1'b0};
      tmin_d       = {minor_span, 1'b0};
      active_d     = major_span != '0;
    end else if (res_valid_o) begin
      if (err_sub[brl_pkg::ERR_BITS-1]) begin
        minor_pos_d = minor_down_q ? minor_pos_q - brl_pkg::COORD_BITS'(1)
                                   : minor_pos_q + brl_pkg::COORD_BITS'(1);
        err_d       = err_sub + $signed(brl_pkg::ERR_BITS'(tmaj_q));
      end else begin
        err_d = err_sub;
      end
      major_pos_d = major_next[brl_pkg::COORD_BITS-1:0];
      if (last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      steep_q      <= 1'b0;
      major_pos_q  <= '0;
      major_stop_q <= '0;
      minor_pos_q  <= '0;
      minor_down_q <= 1'b0;
      err_q        <= '0;
      tmaj_q       <= '0;
      tmin_q       <= '0;
    end else begin
      active_q     <= active_d;
      steep_q      <= steep_d;
      major_pos_q  <= major_pos_d;
      major_stop_q <= major_stop_d;
      minor_pos_q  <= minor_pos_d;
      minor_down_q <= minor_down_d;
      err_q        <= err_d;
      tmaj_q       <= tmaj_d;
      tmin_q       <= tmin_d;
    end
  end

endmodule

// ===== sv/brl_out_buf.sv =====
// ----------------------------------------------------------------------------
// brl_out_buf: pixel result register with skid stage
// Two-entry buffer that decouples the pixel channel from the command side.
// ----------------------------------------------------------------------------
module brl_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  brl_pkg::pixel_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            pop_ready_i,
  output brl_pkg::pixel_t data_o
);

  logic            main_vld_q, skid_vld_q;
  brl_pkg::pixel_t main_q, skid_q;
  logic            pop;

  assign pop     = main_vld_q && pop_ready_i;
  assign ready_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!main_vld_q || pop) begin
      main_vld_q <= push_i;
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (!main_vld_q || pop) begin
      main_q <= data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

endmodule
